[hdl/assert_macros.svh]
// assertion macros for the rtl files, used by ufl_queue
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`define ASSERT_IMPLY_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define ASSERT_NEVER(label, clk, rst, cond)
`define ASSERT_IMPLY_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/ufl_pkg.sv]
// shared types, widths, codes and rounding helpers for the unicycle speed block
// no dependencies
package ufl_pkg;

   localparam int SPEED_WIDTH  = 16;
   localparam int ANGLE_WIDTH  = 16;
   localparam int LEAD_W       = 16;
   localparam int LIM_W        = 15;
   localparam int STEPS        = 16;
   localparam int CORDIC_W     = 33;
   localparam int CS_W         = 17;
   localparam int PROD_W       = CS_W + SPEED_WIDTH;
   localparam int SUM_W        = PROD_W + 1;
   localparam int V_W          = SUM_W - 14;
   localparam int WP_W         = SUM_W + LEAD_W + 1;
   localparam int W_W          = WP_W - 22;
   localparam int DEN_W        = W_W;
   localparam int NUM_W        = W_W + LIM_W + 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam int ADDR_W       = 4;
   localparam int CSR_W        = 32;

   localparam logic signed [CORDIC_W-1:0] X_START = CORDIC_W'(652032874);

   localparam logic [31:0] ATAN_TABLE [STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_LINEAR  = 2'd1;
   localparam logic [1:0] KIND_ANGULAR = 2'd2;

   localparam logic [1:0] REG_LEAD_INVERSE = 2'd0;
   localparam logic [1:0] REG_MAX_LINEAR   = 2'd1;
   localparam logic [1:0] REG_MAX_ANGULAR  = 2'd2;

   typedef struct packed {
      logic        [ANGLE_WIDTH-1:0] heading;
      logic signed [SPEED_WIDTH-1:0] desired_vx;
      logic signed [SPEED_WIDTH-1:0] desired_vy;
   } req_type;

   typedef struct packed {
      logic signed [SPEED_WIDTH-1:0] linear_speed;
      logic signed [SPEED_WIDTH-1:0] angular_speed;
      logic        [1:0]             limit_kind;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic        [1:0]       kind;
      logic signed [W_W-1:0]   v;
      logic signed [W_W-1:0]   w;
      logic                    v_neg;
      logic                    w_neg;
      logic        [LIM_W-1:0] v_lim;
      logic        [LIM_W-1:0] w_lim;
      logic        [NUM_W-1:0] num;
      logic        [DEN_W-1:0] den;
   } job_type;

   // round half away from zero, drop 15 bits
   function automatic logic signed [CS_W-1:0] rnd_cs(input logic signed [CORDIC_W-1:0] val);
      logic signed [CORDIC_W-1:0] bias;
      logic signed [CORDIC_W-1:0] t;
      bias = val[CORDIC_W-1] ? CORDIC_W'(16383) : CORDIC_W'(16384);
      t = (val + bias) >>> 15;
      return t[CS_W-1:0];
   endfunction

   function automatic logic signed [V_W-1:0] rnd_v(input logic signed [SUM_W-1:0] val);
      logic signed [SUM_W-1:0] bias;
      logic signed [SUM_W-1:0] t;
      bias = val[SUM_W-1] ? SUM_W'(16383) : SUM_W'(16384);
      t = (val + bias) >>> 15;
      return t[V_W-1:0];
   endfunction

   function automatic logic signed [W_W-1:0] rnd_w(input logic signed [WP_W-1:0] val);
      logic signed [WP_W-1:0] bias;
      logic signed [WP_W-1:0] t;
      bias = val[WP_W-1] ? WP_W'(23'h3FFFFF) : WP_W'(23'h400000);
      t = (val + bias) >>> 23;
      return t[W_W-1:0];
   endfunction

   function automatic logic signed [SPEED_WIDTH-1:0] sat_speed(input logic signed [W_W-1:0] val);
      logic signed [W_W-1:0] hi;
      logic signed [W_W-1:0] lo;
      hi = W_W'((2 ** (SPEED_WIDTH - 1)) - 1);
      lo = -hi - W_W'(1);
      if (val > hi) return hi[SPEED_WIDTH-1:0];
      else if (val < lo) return lo[SPEED_WIDTH-1:0];
      return val[SPEED_WIDTH-1:0];
   endfunction

endpackage

[hdl/unicycle_feedback_linearize_sat.sv]
// unicycle feedback linearization with direction-keeping speed limit
// 24-stage front (16-step cordic), queue, 18-stage back (16-step divider)
// throughput: one item per cycle when nothing stalls;
// the 4-entry queue lets the front keep going while rsp stalls
// reset: synchronous active high, empties all stages, loads the csr reset values
module unicycle_feedback_linearize_sat (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ufl_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ufl_pkg::rsp_type            rsp_payload,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ufl_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [ufl_pkg::CSR_W-1:0]   csr_pwdata,
   output logic [ufl_pkg::CSR_W-1:0]   csr_prdata,
   output logic                        csr_pready
);
   import ufl_pkg::*;

   // configuration registers
   logic [LEAD_W-1:0] lead_inverse_ff;
   logic [LIM_W-1:0]  max_linear_ff;
   logic [LIM_W-1:0]  max_angular_ff;
   logic              csr_write;
   logic [1:0]        csr_index;

   // front to queue to back
   logic    fq_valid, fq_ready, qb_valid, qb_ready;
   job_type fq_job, qb_job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[ADDR_W-1:2];

   // writes beyond the register list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_inverse_ff <= LEAD_W'(2560);
         max_linear_ff   <= LIM_W'(2048);
         max_angular_ff  <= LIM_W'(12412);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LEAD_INVERSE: lead_inverse_ff <= csr_pwdata[LEAD_W-1:0];
            REG_MAX_LINEAR:   max_linear_ff   <= csr_pwdata[LIM_W-1:0];
            REG_MAX_ANGULAR:  max_angular_ff  <= csr_pwdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // read back, unmapped addresses read zero
   always_comb begin
      unique case (csr_index)
         REG_LEAD_INVERSE: csr_prdata = CSR_W'(lead_inverse_ff);
         REG_MAX_LINEAR:   csr_prdata = CSR_W'(max_linear_ff);
         REG_MAX_ANGULAR:  csr_prdata = CSR_W'(max_angular_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // sine/cosine, speeds and classification
   ufl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .lead_inverse (lead_inverse_ff),
      .max_linear   (max_linear_ff),
      .max_angular  (max_angular_ff),
      .job_valid    (fq_valid),
      .job_ready    (fq_ready),
      .job          (fq_job)
   );

   // decouples front stalls from back stalls
   ufl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_job)
   );

   // scaling divide and saturation, holds the output register
   ufl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (qb_valid),
      .job_ready   (qb_ready),
      .job         (qb_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[hdl/ufl_front.sv]
// front part: cordic sine/cosine, speed products and limit classification
// depends on ufl_pkg
module ufl_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ufl_pkg::req_type            req_payload,
   input  logic [ufl_pkg::LEAD_W-1:0]  lead_inverse,
   input  logic [ufl_pkg::LIM_W-1:0]   max_linear,
   input  logic [ufl_pkg::LIM_W-1:0]   max_angular,
   output logic                        job_valid,
   input  logic                        job_ready,
   output ufl_pkg::job_type            job
);
   import ufl_pkg::*;

   logic en;

   logic                          vld_ff  [0:STEPS];
   logic signed [CORDIC_W-1:0]    x_ff    [0:STEPS];
   logic signed [CORDIC_W-1:0]    y_ff    [0:STEPS];
   logic signed [CORDIC_W-1:0]    z_ff    [0:STEPS];
   logic                          flip_ff [0:STEPS];
   logic signed [SPEED_WIDTH-1:0] vx_ff   [0:STEPS];
   logic signed [SPEED_WIDTH-1:0] vy_ff   [0:STEPS];

   logic [31:0]                ang;
   logic                       flip_in;
   logic signed [CORDIC_W-1:0] z_in;

   logic cs_vld_ff, p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff, p5_vld_ff, job_vld_ff;
   logic signed [CS_W-1:0]        c_ff, s_ff;
   logic signed [SPEED_WIDTH-1:0] cvx_ff, cvy_ff;
   logic signed [CORDIC_W-1:0]    xf, yf;
   logic signed [PROD_W-1:0]      pcx_ff, psy_ff, pcy_ff, psx_ff;
   logic signed [V_W-1:0]         v2_ff, v3_ff;
   logic signed [SUM_W-1:0]       diff_ff;
   logic signed [WP_W-1:0]        wp_ff;
   logic signed [V_W-1:0]         v4_ff, v5_ff;
   logic signed [W_W-1:0]         w4_ff, w5_ff;
   logic        [V_W-1:0]         av4_ff, av5_ff;
   logic        [W_W-1:0]         aw4_ff, aw5_ff;
   logic        [NUM_W-1:0]       lhs_ff, rhs_ff;
   logic signed [W_W-1:0]         w4_in;
   logic        [V_W-1:0]         av4_in;
   logic        [W_W-1:0]         aw4_in;
   logic                          lin, angl;
   job_type                       job_in, job_ff;

   assign en        = !job_vld_ff || job_ready;
   assign req_ready = en;
   assign job_valid = job_vld_ff;
   assign job       = job_ff;

   // fold the left half plane onto the right one, undo with a sign flip later
   always_comb begin
      ang     = {req_payload.heading, {(32 - ANGLE_WIDTH){1'b0}}};
      flip_in = ang[31] ^ ang[30];
      z_in    = CORDIC_W'(signed'({ang[31] ^ flip_in, ang[30:0]}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= X_START;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         flip_ff[0] <= flip_in;
         vx_ff[0]   <= req_payload.desired_vx;
         vy_ff[0]   <= req_payload.desired_vy;
      end
   end

   // one rotation per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_rot
      logic signed [CORDIC_W-1:0] dx, dy, at;
      always_comb begin
         dx = y_ff[k] >>> k;
         dy = x_ff[k] >>> k;
         at = CORDIC_W'(ATAN_TABLE[k]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[k][CORDIC_W-1]) begin
               x_ff[k+1] <= x_ff[k] - dx;
               y_ff[k+1] <= y_ff[k] + dy;
               z_ff[k+1] <= z_ff[k] - at;
            end else begin
               x_ff[k+1] <= x_ff[k] + dx;
               y_ff[k+1] <= y_ff[k] - dy;
               z_ff[k+1] <= z_ff[k] + at;
            end
            flip_ff[k+1] <= flip_ff[k];
            vx_ff[k+1]   <= vx_ff[k];
            vy_ff[k+1]   <= vy_ff[k];
         end
      end
   end

   always_comb begin
      xf = flip_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
      yf = flip_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
      w4_in  = rnd_w(wp_ff);
      av4_in = v3_ff[V_W-1] ? V_W'(-v3_ff) : V_W'(v3_ff);
      aw4_in = w4_in[W_W-1] ? W_W'(-w4_in) : W_W'(w4_in);
      lin    = (lhs_ff >= rhs_ff) && (W_W'(av5_ff) > W_W'(max_linear));
      angl   = !lin && (rhs_ff > lhs_ff) && (aw5_ff > W_W'(max_angular));
      job_in.kind  = lin ? KIND_LINEAR : (angl ? KIND_ANGULAR : KIND_NONE);
      job_in.v     = W_W'(v5_ff);
      job_in.w     = w5_ff;
      job_in.v_neg = v5_ff[V_W-1];
      job_in.w_neg = w5_ff[W_W-1];
      job_in.v_lim = max_linear;
      job_in.w_lim = max_angular;
      if (lin) begin
         job_in.num = rhs_ff + NUM_W'(av5_ff >> 1);
         job_in.den = DEN_W'(av5_ff);
      end else if (angl) begin
         job_in.num = lhs_ff + NUM_W'(aw5_ff >> 1);
         job_in.den = aw5_ff;
      end else begin
         job_in.num = '0;
         job_in.den = DEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         p4_vld_ff  <= 1'b0;
         p5_vld_ff  <= 1'b0;
         job_vld_ff <= 1'b0;
      end else if (en) begin
         cs_vld_ff  <= vld_ff[STEPS];
         p1_vld_ff  <= cs_vld_ff;
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= p2_vld_ff;
         p4_vld_ff  <= p3_vld_ff;
         p5_vld_ff  <= p4_vld_ff;
         job_vld_ff <= p5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff    <= rnd_cs(xf);
         s_ff    <= rnd_cs(yf);
         cvx_ff  <= vx_ff[STEPS];
         cvy_ff  <= vy_ff[STEPS];
         pcx_ff  <= c_ff * cvx_ff;
         psy_ff  <= s_ff * cvy_ff;
         pcy_ff  <= c_ff * cvy_ff;
         psx_ff  <= s_ff * cvx_ff;
         v2_ff   <= rnd_v(SUM_W'(pcx_ff) + SUM_W'(psy_ff));
         diff_ff <= SUM_W'(pcy_ff) - SUM_W'(psx_ff);
         wp_ff   <= WP_W'(diff_ff) * WP_W'(signed'({1'b0, lead_inverse}));
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         w4_ff   <= w4_in;
         av4_ff  <= av4_in;
         aw4_ff  <= aw4_in;
         lhs_ff  <= NUM_W'(av4_ff) * NUM_W'(max_angular);
         rhs_ff  <= NUM_W'(aw4_ff) * NUM_W'(max_linear);
         v5_ff   <= v4_ff;
         w5_ff   <= w4_ff;
         av5_ff  <= av4_ff;
         aw5_ff  <= aw4_ff;
         job_ff  <= job_in;
      end
   end

endmodule

[hdl/ufl_queue.sv]
// short fifo of classified items between front and back
// depends on ufl_pkg and assert_macros.svh
`include "assert_macros.svh"
module ufl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ufl_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ufl_pkg::job_type pop_data
);
   import ufl_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + PTR_W'(1);
         if (pop) rd_ff <= rd_ff + PTR_W'(1);
         if (push && !pop) count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(QUEUE_DEPTH))
   `ASSERT_NEVER(a_ptr_count, clock, reset, PTR_W'(wr_ff - rd_ff) != count_ff[PTR_W-1:0])
   `ASSERT_IMPLY_NEXT(a_push_grow, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

[hdl/ufl_back.sv]
// back part: pipelined rounding divider for the limited speed and output saturation
// depends on ufl_pkg
module ufl_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  ufl_pkg::job_type job,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ufl_pkg::rsp_type rsp_payload
);
   import ufl_pkg::*;

   localparam int QB = SPEED_WIDTH;

   logic                   en;
   logic                   vld_ff [0:QB];
   logic [NUM_W-1:0]       rem_ff [0:QB];
   logic [QB-1:0]          q_ff   [0:QB];
   job_type                jb_ff  [0:QB];
   logic                   out_vld_ff;
   rsp_type                out_ff, out_in;
   logic signed [W_W-1:0]  qs, vl, wl, v_res, w_res;

   assign en          = !out_vld_ff || rsp_ready;
   assign job_ready   = en;
   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= job.num;
         q_ff[0]   <= '0;
         jb_ff[0]  <= job;
      end
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar k = 0; k < QB; k++) begin : g_div
      logic [NUM_W-1:0] ds;
      logic             ge;
      always_comb begin
         ds = NUM_W'(jb_ff[k].den) << (QB - 1 - k);
         ge = rem_ff[k] >= ds;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? rem_ff[k] - ds : rem_ff[k];
            q_ff[k+1]   <= q_ff[k] | (QB'(ge) << (QB - 1 - k));
            jb_ff[k+1]  <= jb_ff[k];
         end
      end
   end

   always_comb begin
      qs = W_W'(q_ff[QB]);
      vl = W_W'(jb_ff[QB].v_lim);
      wl = W_W'(jb_ff[QB].w_lim);
      unique case (jb_ff[QB].kind)
         KIND_LINEAR: begin
            v_res = jb_ff[QB].v_neg ? -vl : vl;
            w_res = jb_ff[QB].w_neg ? -qs : qs;
         end
         KIND_ANGULAR: begin
            v_res = jb_ff[QB].v_neg ? -qs : qs;
            w_res = jb_ff[QB].w_neg ? -wl : wl;
         end
         default: begin
            v_res = jb_ff[QB].v;
            w_res = jb_ff[QB].w;
         end
      endcase
      out_in.linear_speed  = sat_speed(v_res);
      out_in.angular_speed = sat_speed(w_res);
      out_in.limit_kind    = jb_ff[QB].kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

endmodule
